[rtl/btr_pkg.sv]
package btr_pkg;

	localparam int CHANNELS = 4;
	localparam int CH_W = $clog2(CHANNELS);
	localparam int ADDR_W = 5;
	localparam int DIV_STEPS = 32;
	localparam int CNT_W = $clog2(DIV_STEPS + 1);

	localparam logic [2:0] REG_FILTER_LENGTH = 3'd0;
	localparam logic [2:0] REG_ROLL_CHANNEL  = 3'd1;
	localparam logic [2:0] REG_NICK_CHANNEL  = 3'd2;
	localparam logic [2:0] REG_DOWN_CHANNEL  = 3'd3;
	localparam logic [2:0] REG_ROLL_SCALE    = 3'd4;
	localparam logic [2:0] REG_NICK_SCALE    = 3'd5;
	localparam logic [2:0] REG_DOWN_SCALE    = 3'd6;

	localparam logic signed [31:0] FORCE_ONE = 32'sd65536;
	localparam logic signed [31:0] SMALL_FORCE_VALUE = 32'sd7;
	localparam logic [62:0] SMALL_FORCE_LIMIT = 63'd4294967;
	localparam logic [30:0] FORCE_POS_LIM = 31'd16777215;
	localparam logic [30:0] FORCE_NEG_LIM = 31'd16777216;

	typedef struct packed {
		logic [9:0]         filter_length;
		logic [1:0]         roll_channel;
		logic [1:0]         nick_channel;
		logic [1:0]         down_channel;
		logic signed [31:0] roll_scale;
		logic signed [31:0] nick_scale;
		logic signed [31:0] down_scale;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_FMUL,
		OP_FSUM,
		OP_FDIV,
		OP_FFIN,
		OP_VMUL,
		OP_VRND,
		OP_PMUL,
		OP_TSCL,
		OP_TDIV,
		OP_TFIN,
		OP_DFIN,
		OP_EMIT
	} dp_op_t;

	typedef enum logic [1:0] {
		SC_ROLL,
		SC_NICK,
		SC_DOWN
	} scale_sel_t;

	typedef struct packed {
		dp_op_t     op;
		scale_sel_t sel;
	} cmd_t;

	typedef struct packed {
		logic filt;
		logic is_roll;
		logic is_nick;
		logic is_down;
		logic div_done;
		logic out_free;
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FMUL,
		S_FSUM,
		S_FDIV,
		S_FWAIT,
		S_FFIN,
		S_VMUL,
		S_VRND,
		S_TMUL,
		S_TSCL,
		S_TDIV,
		S_TWAIT,
		S_TFIN,
		S_DMUL,
		S_DFIN,
		S_EMIT
	} state_t;

	function automatic logic [31:0] sat32(input logic neg, input logic ovf,
			input logic [32:0] m);
		logic [31:0] r;
		if (neg) begin
			if (ovf || m >= 33'h0_8000_0000)
				r = 32'h8000_0000;
			else
				r = 32'(33'd0 - m);
		end else begin
			if (ovf || m >= 33'h0_7FFF_FFFF)
				r = 32'h7FFF_FFFF;
			else
				r = m[31:0];
		end
		return r;
	endfunction

endpackage

[rtl/bridge_filter_tilt_ratio.sv]
// Load-bridge low-pass filter and tilt ratio. One item is taken at a time; it
// runs the filter divide when the filter is used, then a tangent for a roll
// or nick channel (both when one channel has both roles) and a down-force
// update for the down channel. The filter divide and each tangent run on the
// 32-step shared restoring divider. The next item is taken while the previous
// result waits in the output register.
module bridge_filter_tilt_ratio (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [39:0]                 s_axis_tdata,  // sample, settled, zero pad
	input  logic [1:0]                  s_axis_tuser,  // channel
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [95:0]                 m_axis_tdata,  // force_res, roll_valid,
	                                                   // roll_tangent, nick_valid,
	                                                   // nick_tangent, zero pad
	output logic [1:0]                  m_axis_tuser,  // out_channel
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [btr_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	btr_pkg::cfg_t    cfg_q;
	btr_pkg::cmd_t    cmd;
	btr_pkg::status_t status;
	logic [2:0]       reg_idx;
	logic             cfg_wr;
	logic [24:0]      force_res;
	logic             roll_valid;
	logic [31:0]      roll_tangent;
	logic             nick_valid;
	logic [31:0]      nick_tangent;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_length <= 10'd0;
			cfg_q.roll_channel  <= 2'd0;
			cfg_q.nick_channel  <= 2'd1;
			cfg_q.down_channel  <= 2'd2;
			cfg_q.roll_scale    <= btr_pkg::FORCE_ONE;
			cfg_q.nick_scale    <= btr_pkg::FORCE_ONE;
			cfg_q.down_scale    <= btr_pkg::FORCE_ONE;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				btr_pkg::REG_FILTER_LENGTH: cfg_q.filter_length <= pwdata[9:0];
				btr_pkg::REG_ROLL_CHANNEL:  cfg_q.roll_channel  <= pwdata[1:0];
				btr_pkg::REG_NICK_CHANNEL:  cfg_q.nick_channel  <= pwdata[1:0];
				btr_pkg::REG_DOWN_CHANNEL:  cfg_q.down_channel  <= pwdata[1:0];
				btr_pkg::REG_ROLL_SCALE:    cfg_q.roll_scale    <= pwdata;
				btr_pkg::REG_NICK_SCALE:    cfg_q.nick_scale    <= pwdata;
				btr_pkg::REG_DOWN_SCALE:    cfg_q.down_scale    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			btr_pkg::REG_FILTER_LENGTH: prdata = 32'(cfg_q.filter_length);
			btr_pkg::REG_ROLL_CHANNEL:  prdata = 32'(cfg_q.roll_channel);
			btr_pkg::REG_NICK_CHANNEL:  prdata = 32'(cfg_q.nick_channel);
			btr_pkg::REG_DOWN_CHANNEL:  prdata = 32'(cfg_q.down_channel);
			btr_pkg::REG_ROLL_SCALE:    prdata = cfg_q.roll_scale;
			btr_pkg::REG_NICK_SCALE:    prdata = cfg_q.nick_scale;
			btr_pkg::REG_DOWN_SCALE:    prdata = cfg_q.down_scale;
			default:                    prdata = '0;
		endcase
	end

	btr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	btr_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.status       (status),
		.in_channel   (s_axis_tuser),
		.in_sample    (s_axis_tdata[31:0]),
		.in_settled   (s_axis_tdata[32]),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.out_channel  (m_axis_tuser),
		.force_res    (force_res),
		.roll_valid   (roll_valid),
		.roll_tangent (roll_tangent),
		.nick_valid   (nick_valid),
		.nick_tangent (nick_tangent)
	);

	assign m_axis_tdata = {5'd0, nick_tangent, nick_valid, roll_tangent, roll_valid, force_res};

endmodule

[rtl/btr_div.sv]
module btr_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] hi,
	input  logic [31:0] lo,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [31:0] quo,
	output logic [31:0] rem
);

	logic [31:0]                rem_q;
	logic [31:0]                quo_q;
	logic [31:0]                dvs_q;
	logic [btr_pkg::CNT_W-1:0]  cnt_q;
	logic                       done_q;
	logic [32:0]                trial;
	logic [32:0]                diff;
	logic                       ge;

	assign trial = {rem_q, quo_q[31]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == btr_pkg::CNT_W'(1));
			if (start)
				cnt_q <= btr_pkg::CNT_W'(btr_pkg::DIV_STEPS);
			else if (cnt_q != '0)
				cnt_q <= cnt_q - btr_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= hi;
			quo_q <= lo;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign busy = cnt_q != '0;
	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

[rtl/btr_datapath.sv]
module btr_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  btr_pkg::cfg_t              cfg,
	input  btr_pkg::cmd_t              cmd,
	output btr_pkg::status_t           status,
	input  logic [btr_pkg::CH_W-1:0]   in_channel,
	input  logic signed [31:0]         in_sample,
	input  logic                       in_settled,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic [btr_pkg::CH_W-1:0]   out_channel,
	output logic [24:0]                force_res,
	output logic                       roll_valid,
	output logic [31:0]                roll_tangent,
	output logic                       nick_valid,
	output logic [31:0]                nick_tangent
);

	logic [btr_pkg::CH_W-1:0] ch_q;
	logic signed [31:0]       sample_q;
	logic                     settled_q;
	logic signed [31:0]       old_q;
	logic signed [42:0]       prod_q;
	logic                     num_neg_q;
	logic [41:0]              num_mag_q;
	logic signed [31:0]       mn_q;
	logic signed [46:0]       fprod_q;
	logic [24:0]              force_q;
	logic signed [63:0]       pprod_q;
	logic                     tneg_q;
	logic [55:0]              nh_q;
	logic [15:0]              nl_q;
	logic                     ovf_q;
	logic                     roll_v_q;
	logic [31:0]              roll_t_q;
	logic                     nick_v_q;
	logic [31:0]              nick_t_q;
	logic signed [31:0]       df_q;
	logic signed [31:0]       chval_q [btr_pkg::CHANNELS];

	logic                     oval_q;
	logic [btr_pkg::CH_W-1:0] och_q;
	logic [24:0]              oforce_q;
	logic                     orv_q;
	logic [31:0]              ort_q;
	logic                     onv_q;
	logic [31:0]              ont_q;

	logic [9:0]               nm1;
	logic                     filt;
	logic signed [42:0]       num;
	logic [31:0]              df_mag;
	logic signed [31:0]       scale_val;
	logic [62:0]              pm;
	logic [71:0]              nfull;
	logic [45:0]              fmag;
	logic [30:0]              fr;
	logic [24:0]              force_d;
	logic [47:0]              rr;
	logic                     div_start;
	logic                     div_busy;
	logic                     div_done;
	logic [31:0]              div_hi;
	logic [31:0]              div_lo;
	logic [31:0]              div_dvs;
	logic [31:0]              div_quo;
	logic [31:0]              div_rem;
	logic                     f_inc;
	logic                     t_inc;
	logic [32:0]              m_f;
	logic [32:0]              m_t;
	logic [31:0]              t_res;
	logic                     out_free;

	assign nm1    = cfg.filter_length - 10'd1;
	assign filt   = settled_q && (cfg.filter_length > 10'd1);
	assign num    = prod_q + 43'(sample_q);
	assign df_mag = df_q[31] ? 32'(-df_q) : 32'(df_q);
	assign pm     = pprod_q[63] ? 63'(-pprod_q) : 63'(pprod_q);
	assign nfull  = 72'(pm) * 72'd1000;
	assign fmag   = fprod_q[46] ? 46'(-fprod_q) : 46'(fprod_q);
	assign fr     = 31'((47'(fmag) + 47'd32768) >> 16);
	assign rr     = 48'((64'(pm) + 64'd32768) >> 16);

	always_comb begin
		case (cmd.sel)
			btr_pkg::SC_NICK: scale_val = cfg.nick_scale;
			btr_pkg::SC_DOWN: scale_val = cfg.down_scale;
			default:          scale_val = cfg.roll_scale;
		endcase
	end

	always_comb begin
		if (fprod_q[46])
			force_d = (fr >= btr_pkg::FORCE_NEG_LIM) ? 25'h1000000 : 25'(31'd0 - fr);
		else
			force_d = (fr >= btr_pkg::FORCE_POS_LIM) ? 25'h0FFFFFF : fr[24:0];
	end

	assign div_start = (cmd.op == btr_pkg::OP_FDIV) || (cmd.op == btr_pkg::OP_TDIV);

	always_comb begin
		if (cmd.op == btr_pkg::OP_TDIV) begin
			div_hi  = 32'(nh_q[55:32]);
			div_lo  = nh_q[31:0];
			div_dvs = df_mag;
		end else begin
			div_hi  = 32'(num_mag_q[41:32]);
			div_lo  = num_mag_q[31:0];
			div_dvs = 32'(cfg.filter_length);
		end
	end

	btr_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.hi      (div_hi),
		.lo      (div_lo),
		.divisor (div_dvs),
		.busy    (div_busy),
		.done    (div_done),
		.quo     (div_quo),
		.rem     (div_rem)
	);

	assign f_inc = {div_rem, 1'b0} >= 33'(cfg.filter_length);
	assign t_inc = {div_rem, nl_q, 1'b0} >= {1'b0, df_mag, 16'd0};
	assign m_f   = 33'(div_quo) + 33'(f_inc);
	assign m_t   = 33'(div_quo) + 33'(t_inc);
	assign t_res = btr_pkg::sat32(tneg_q, ovf_q, m_t);

	assign out_free = !oval_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
			df_q   <= btr_pkg::FORCE_ONE;
			for (int i = 0; i < btr_pkg::CHANNELS; i++)
				chval_q[i] <= '0;
		end else begin
			if (cmd.op == btr_pkg::OP_EMIT)
				oval_q <= 1'b1;
			else if (out_ready)
				oval_q <= 1'b0;
			if (cmd.op == btr_pkg::OP_VMUL)
				chval_q[ch_q] <= mn_q;
			if (cmd.op == btr_pkg::OP_DFIN) begin
				if (pm <= btr_pkg::SMALL_FORCE_LIMIT)
					df_q <= btr_pkg::SMALL_FORCE_VALUE;
				else
					df_q <= btr_pkg::sat32(pprod_q[63], |rr[47:33], rr[32:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			btr_pkg::OP_LOAD: begin
				ch_q      <= in_channel;
				sample_q  <= in_sample;
				settled_q <= in_settled;
				old_q     <= chval_q[in_channel];
				roll_v_q  <= 1'b0;
				roll_t_q  <= '0;
				nick_v_q  <= 1'b0;
				nick_t_q  <= '0;
			end
			btr_pkg::OP_FMUL: prod_q <= 43'(old_q) * $signed(43'(nm1));
			btr_pkg::OP_FSUM: begin
				num_neg_q <= num[42];
				num_mag_q <= num[42] ? 42'(-num) : 42'(num);
			end
			btr_pkg::OP_FDIV: ovf_q <= div_hi >= div_dvs;
			btr_pkg::OP_FFIN: mn_q <= filt ? btr_pkg::sat32(num_neg_q, ovf_q, m_f) : sample_q;
			btr_pkg::OP_VMUL: fprod_q <= 47'(mn_q) * 47'sd10000;
			btr_pkg::OP_VRND: force_q <= force_d;
			btr_pkg::OP_PMUL: pprod_q <= 64'(mn_q) * 64'(scale_val);
			btr_pkg::OP_TSCL: begin
				tneg_q <= pprod_q[63] ^ df_q[31];
				nh_q   <= nfull[71:16];
				nl_q   <= nfull[15:0];
			end
			btr_pkg::OP_TDIV: ovf_q <= div_hi >= div_dvs;
			btr_pkg::OP_TFIN: begin
				if (cmd.sel == btr_pkg::SC_NICK) begin
					nick_v_q <= 1'b1;
					nick_t_q <= t_res;
				end else begin
					roll_v_q <= 1'b1;
					roll_t_q <= t_res;
				end
			end
			btr_pkg::OP_EMIT: begin
				och_q    <= ch_q;
				oforce_q <= force_q;
				orv_q    <= roll_v_q;
				ort_q    <= roll_t_q;
				onv_q    <= nick_v_q;
				ont_q    <= nick_t_q;
			end
			default: ;
		endcase
	end

	assign status.filt     = filt;
	assign status.is_roll  = ch_q == cfg.roll_channel;
	assign status.is_nick  = ch_q == cfg.nick_channel;
	assign status.is_down  = ch_q == cfg.down_channel;
	assign status.div_done = div_done;
	assign status.out_free = out_free;

	assign out_valid    = oval_q;
	assign out_channel  = och_q;
	assign force_res    = oforce_q;
	assign roll_valid   = orv_q;
	assign roll_tangent = ort_q;
	assign nick_valid   = onv_q;
	assign nick_tangent = ont_q;

	a_df_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		df_q != '0)
		else $error("down force reached zero");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == btr_pkg::OP_EMIT |-> out_free)
		else $error("result overwrote a pending item");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == btr_pkg::OP_EMIT |=> oval_q)
		else $error("emitted item not presented");

endmodule

[rtl/btr_ctrl.sv]
module btr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  btr_pkg::status_t status,
	output btr_pkg::cmd_t    cmd
);

	btr_pkg::state_t     state_q;
	btr_pkg::state_t     state_d;
	btr_pkg::scale_sel_t sel_q;
	btr_pkg::scale_sel_t sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btr_pkg::S_IDLE;
			sel_q   <= btr_pkg::SC_ROLL;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		sel_d    = sel_q;
		in_ready = 1'b0;
		cmd.op   = btr_pkg::OP_NONE;
		cmd.sel  = sel_q;
		unique case (state_q)
			btr_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = btr_pkg::OP_LOAD;
					state_d = btr_pkg::S_FMUL;
				end
			end
			btr_pkg::S_FMUL: begin
				cmd.op  = btr_pkg::OP_FMUL;
				state_d = btr_pkg::S_FSUM;
			end
			btr_pkg::S_FSUM: begin
				cmd.op  = btr_pkg::OP_FSUM;
				state_d = status.filt ? btr_pkg::S_FDIV : btr_pkg::S_FFIN;
			end
			btr_pkg::S_FDIV: begin
				cmd.op  = btr_pkg::OP_FDIV;
				state_d = btr_pkg::S_FWAIT;
			end
			btr_pkg::S_FWAIT: begin
				if (status.div_done)
					state_d = btr_pkg::S_FFIN;
			end
			btr_pkg::S_FFIN: begin
				cmd.op  = btr_pkg::OP_FFIN;
				state_d = btr_pkg::S_VMUL;
			end
			btr_pkg::S_VMUL: begin
				cmd.op  = btr_pkg::OP_VMUL;
				state_d = btr_pkg::S_VRND;
			end
			btr_pkg::S_VRND: begin
				cmd.op = btr_pkg::OP_VRND;
				if (status.is_roll) begin
					sel_d   = btr_pkg::SC_ROLL;
					state_d = btr_pkg::S_TMUL;
				end else if (status.is_nick) begin
					sel_d   = btr_pkg::SC_NICK;
					state_d = btr_pkg::S_TMUL;
				end else if (status.is_down) begin
					state_d = btr_pkg::S_DMUL;
				end else begin
					state_d = btr_pkg::S_EMIT;
				end
			end
			btr_pkg::S_TMUL: begin
				cmd.op  = btr_pkg::OP_PMUL;
				state_d = btr_pkg::S_TSCL;
			end
			btr_pkg::S_TSCL: begin
				cmd.op  = btr_pkg::OP_TSCL;
				state_d = btr_pkg::S_TDIV;
			end
			btr_pkg::S_TDIV: begin
				cmd.op  = btr_pkg::OP_TDIV;
				state_d = btr_pkg::S_TWAIT;
			end
			btr_pkg::S_TWAIT: begin
				if (status.div_done)
					state_d = btr_pkg::S_TFIN;
			end
			btr_pkg::S_TFIN: begin
				cmd.op = btr_pkg::OP_TFIN;
				if (sel_q == btr_pkg::SC_ROLL && status.is_nick) begin
					sel_d   = btr_pkg::SC_NICK;
					state_d = btr_pkg::S_TMUL;
				end else if (status.is_down) begin
					state_d = btr_pkg::S_DMUL;
				end else begin
					state_d = btr_pkg::S_EMIT;
				end
			end
			btr_pkg::S_DMUL: begin
				cmd.op  = btr_pkg::OP_PMUL;
				cmd.sel = btr_pkg::SC_DOWN;
				state_d = btr_pkg::S_DFIN;
			end
			btr_pkg::S_DFIN: begin
				cmd.op  = btr_pkg::OP_DFIN;
				state_d = btr_pkg::S_EMIT;
			end
			btr_pkg::S_EMIT: begin
				if (status.out_free) begin
					cmd.op  = btr_pkg::OP_EMIT;
					state_d = btr_pkg::S_IDLE;
				end
			end
			default: state_d = btr_pkg::S_IDLE;
		endcase
	end

endmodule

[test/bridge_filter_tilt_ratio_tb.sv]
module bridge_filter_tilt_ratio_tb;
	import btr_pkg::*;

	localparam longint S32_MIN = -64'sd2147483648;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint FORCE_MIN_L = -64'sd16777216;
	localparam longint FORCE_MAX_L = 64'sd16777215;
	localparam longint FORCE_GAIN = 64'sd10000;
	localparam longint TANGENT_GAIN = 64'sd1000;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 250;

	typedef struct packed {
		logic [1:0]         channel;
		logic signed [24:0] force_res;
		logic               roll_valid;
		logic signed [31:0] roll_tangent;
		logic               nick_valid;
		logic signed [31:0] nick_tangent;
	} reading_t;

	class tilt_ratio_board;
		cfg_t               regs;
		logic signed [31:0] level [CHANNELS];
		logic signed [31:0] down_force;
		reading_t           due_readings [$];
		int                 errors;

		function new();
			regs.filter_length = '0;
			regs.roll_channel = 2'd0;
			regs.nick_channel = 2'd1;
			regs.down_channel = 2'd2;
			regs.roll_scale = FORCE_ONE;
			regs.nick_scale = FORCE_ONE;
			regs.down_scale = FORCE_ONE;
			foreach (level[i])
				level[i] = '0;
			down_force = FORCE_ONE;
			errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				REG_FILTER_LENGTH: regs.filter_length = val[9:0];
				REG_ROLL_CHANNEL:  regs.roll_channel = val[1:0];
				REG_NICK_CHANNEL:  regs.nick_channel = val[1:0];
				REG_DOWN_CHANNEL:  regs.down_channel = val[1:0];
				REG_ROLL_SCALE:    regs.roll_scale = val;
				REG_NICK_SCALE:    regs.nick_scale = val;
				REG_DOWN_SCALE:    regs.down_scale = val;
				default: ;
			endcase
		endfunction

		function logic [127:0] magnitude(longint x);
			return (x < 0) ? 128'(-x) : 128'(x);
		endfunction

		// round to nearest, halves away from zero
		function logic [127:0] div_nearest(logic [127:0] m, logic [127:0] d);
			logic [127:0] q;
			logic [127:0] r;
			q = m / d;
			r = m % d;
			if (r >= d - r)
				q = q + 1;
			return q;
		endfunction

		function longint clamp(bit neg, logic [127:0] m, longint lo, longint hi);
			if (neg) begin
				if (m >= 128'(-lo))
					return lo;
				return -longint'(m);
			end
			if (m >= 128'(hi))
				return hi;
			return longint'(m);
		endfunction

		function logic signed [31:0] tangent(logic signed [31:0] value, logic signed [31:0] scale);
			longint       p;
			logic [127:0] d;
			p = longint'(value) * longint'($signed(scale));
			d = magnitude(longint'(down_force)) << 16;
			return 32'(clamp((p < 0) != (down_force < 0),
				div_nearest(magnitude(p) * 128'(TANGENT_GAIN), d), S32_MIN, S32_MAX));
		endfunction

		function void note_sample(logic [1:0] ch, logic signed [31:0] smp, logic settled);
			longint   n;
			longint   num;
			longint   mn;
			longint   p;
			reading_t r;
			n = longint'(regs.filter_length);
			if (settled && n > 1) begin
				num = longint'(level[ch]) * (n - 1) + longint'(smp);
				mn = clamp(num < 0, div_nearest(magnitude(num), 128'(n)), S32_MIN, S32_MAX);
			end else begin
				mn = longint'(smp);
			end
			level[ch] = 32'(mn);
			r = '0;
			r.channel = ch;
			r.force_res = 25'(clamp(mn < 0, div_nearest(magnitude(mn * FORCE_GAIN), 128'd65536),
				FORCE_MIN_L, FORCE_MAX_L));
			if (ch == regs.roll_channel) begin
				r.roll_valid = 1'b1;
				r.roll_tangent = tangent(32'(mn), regs.roll_scale);
			end
			if (ch == regs.nick_channel) begin
				r.nick_valid = 1'b1;
				r.nick_tangent = tangent(32'(mn), regs.nick_scale);
			end
			// update the divisor only after both tangents used the old one
			if (ch == regs.down_channel) begin
				p = mn * longint'($signed(regs.down_scale));
				if (magnitude(p) <= 128'(SMALL_FORCE_LIMIT))
					down_force = SMALL_FORCE_VALUE;
				else
					down_force = 32'(clamp(p < 0, div_nearest(magnitude(p), 128'd65536),
						S32_MIN, S32_MAX));
			end
			due_readings.push_back(r);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task compare(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("%s: got %h, expected %h", name, got, want));
		endtask

		task check_reading(logic [1:0] ch, logic [95:0] data);
			reading_t want;
			if (due_readings.size() == 0) begin
				report($sformatf("item on channel %0d with nothing outstanding", ch));
				return;
			end
			want = due_readings.pop_front();
			compare("out_channel", ch, want.channel);
			compare("force_res", data[24:0], $unsigned(want.force_res));
			compare("roll_valid", data[25], want.roll_valid);
			compare("roll_tangent", data[57:26], $unsigned(want.roll_tangent));
			compare("nick_valid", data[58], want.nick_valid);
			compare("nick_tangent", data[90:59], $unsigned(want.nick_tangent));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [39:0]       s_axis_tdata;  // sample, settled, zero pad
	logic [1:0]        s_axis_tuser;  // channel
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [95:0]       m_axis_tdata;  // force_res, roll_valid, roll_tangent, nick_valid,
	                                  // nick_tangent, zero pad
	logic [1:0]        m_axis_tuser;  // out_channel
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	int send_idle;
	int recv_idle;
	int hold_cycles;

	tilt_ratio_board board = new();

	bridge_filter_tilt_ratio u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#12_000_000;
		$display("bridge_filter_tilt_ratio regression: fail");
		$finish;
	end

	task automatic offer_sample(logic [1:0] ch, logic signed [31:0] smp, logic settled);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'b0, settled, smp};
		s_axis_tuser <= ch;
		do @(posedge clk); while (!s_axis_tready);
		board.note_sample(ch, smp, settled);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (board.due_readings.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.set_reg(idx, val);
	endtask

	// unused upper bits carry noise
	task automatic load_setting(cfg_t c);
		write_reg(REG_FILTER_LENGTH, {22'($urandom), c.filter_length});
		write_reg(REG_ROLL_CHANNEL, {30'($urandom), c.roll_channel});
		write_reg(REG_NICK_CHANNEL, {30'($urandom), c.nick_channel});
		write_reg(REG_DOWN_CHANNEL, {30'($urandom), c.down_channel});
		write_reg(REG_ROLL_SCALE, c.roll_scale);
		write_reg(REG_NICK_SCALE, c.nick_scale);
		write_reg(REG_DOWN_SCALE, c.down_scale);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic signed [31:0] near_unity();
		return 32'(int'($urandom_range(262144)) - 131072);
	endfunction

	function automatic cfg_t pick_setting(int k);
		cfg_t c;
		c.filter_length = 10'($urandom);
		c.roll_channel = 2'($urandom);
		c.nick_channel = 2'($urandom);
		c.down_channel = 2'($urandom);
		c.roll_scale = $urandom;
		c.nick_scale = $urandom;
		c.down_scale = $urandom;
		case (k)
			0: begin
				c.filter_length = 10'd2;
				c.roll_channel = 2'd0;
				c.nick_channel = 2'd1;
				c.down_channel = 2'd2;
				c.roll_scale = FORCE_ONE;
				c.nick_scale = FORCE_ONE;
				c.down_scale = FORCE_ONE;
			end
			1: begin
				c.filter_length = 10'd1023;
				c.roll_channel = 2'd3;
				c.nick_channel = 2'd3;
				c.down_channel = 2'd3;
				c.roll_scale = 32'h7FFF_FFFF;
				c.nick_scale = 32'h8000_0000;
				c.down_scale = 32'h8000_0000;
			end
			2: begin
				c.filter_length = 10'd1;
				c.roll_channel = 2'd2;
				c.nick_channel = 2'd2;
				c.down_channel = 2'd0;
				c.roll_scale = 32'sd0;
				c.nick_scale = -32'sd1;
				c.down_scale = 32'sd0;
			end
			3: begin
				c.filter_length = 10'($urandom_range(2, 16));
				c.roll_scale = near_unity();
				c.nick_scale = near_unity();
				c.down_scale = near_unity();
			end
			5: c.filter_length = 10'd0;
			6: begin
				c.filter_length = 10'd3;
				c.down_scale = near_unity();
			end
			default: ;
		endcase
		return c;
	endfunction

	function automatic logic signed [31:0] pick_sample();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(5))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'sd0;
					3: return 32'(int'($urandom_range(132)) - 66);
					4: return 32'sd2048;
					default: return -32'sd2048;
				endcase
			end
			1, 2, 3: return 32'(int'($urandom_range(400000)) - 200000);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int stall_left;
		stall_left = 0;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				board.check_reading(m_axis_tuser, m_axis_tdata);
			if (hold_cycles > 0) begin
				stall_left = hold_cycles;
				hold_cycles = 0;
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	initial begin
		cfg_t c;
		arst_n = 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		send_idle = 31;
		recv_idle = 57;
		hold_cycles = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: filter bypassed, divisor 1.0 until the first down item
		offer_sample(2'd0, 32'sd0, 1'b0);
		offer_sample(2'd0, 32'h7FFF_FFFF, 1'b1);
		offer_sample(2'd1, 32'h8000_0000, 1'b0);
		offer_sample(2'd3, 32'sd2048, 1'b1);
		offer_sample(2'd3, -32'sd2048, 1'b0);
		offer_sample(2'd2, 32'sd65, 1'b0);
		offer_sample(2'd0, 32'h7FFF_FFFF, 1'b0);
		offer_sample(2'd1, 32'h8000_0000, 1'b1);
		offer_sample(2'd0, -32'sd1, 1'b0);
		offer_sample(2'd2, -32'sd66, 1'b1);
		offer_sample(2'd1, 32'sd1000, 1'b0);
		offer_sample(2'd2, -32'sd65, 1'b0);
		offer_sample(2'd2, 32'sd0, 1'b1);
		offer_sample(2'd2, 32'h8000_0000, 1'b0);
		offer_sample(2'd0, 32'h7FFF_FFFF, 1'b1);

		// all roles on one channel, longest filter, extreme scales
		settle();
		load_setting(pick_setting(1));
		offer_sample(2'd3, 32'h7FFF_FFFF, 1'b1);
		offer_sample(2'd3, 32'h8000_0000, 1'b1);
		offer_sample(2'd3, 32'sd5, 1'b0);
		offer_sample(2'd0, 32'h8000_0000, 1'b1);

		// shortest filter: halves round away from zero
		settle();
		load_setting(pick_setting(0));
		offer_sample(2'd3, 32'sd0, 1'b1);
		offer_sample(2'd3, -32'sd7, 1'b1);
		offer_sample(2'd3, -32'sd1, 1'b1);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			if (ph == 3) begin
				send_idle = 57;
				recv_idle = 31;
			end
			if (ph == 6) begin
				send_idle = 0;
				recv_idle = 0;
			end
			c = pick_setting(ph);
			load_setting(c);
			if (ph == 1)
				hold_cycles = 600;
			repeat (ITEMS_PER_PHASE)
				offer_sample(2'($urandom), pick_sample(), $urandom_range(99) < 85);
		end

		settle();
		repeat (150) @(posedge clk);
		if (board.errors == 0)
			$display("bridge_filter_tilt_ratio regression: pass");
		else
			$display("bridge_filter_tilt_ratio regression: fail");
		$finish;
	end

endmodule
